[hdl/cpql_pkg.sv]
// Shared types and constants for the CIGAR parser with query-length total.
`default_nettype none
package cpql_pkg;

	localparam int LEN_BITS_DEF = 32;
	localparam int OUT_BITS     = 32;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_EQUAL = 8'h3D;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_M     = 8'h4D;
	localparam logic [7:0] CH_I     = 8'h49;
	localparam logic [7:0] CH_D     = 8'h44;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_ZERO_LEN    = 3'd1,
		ST_BAD_CHAR    = 3'd2,
		ST_MISSING_OP  = 3'd3,
		ST_UNSUPPORTED = 3'd4,
		ST_OVERFLOW    = 3'd5
	} status_t;

	typedef struct packed {
		logic                has_res;
		logic                op_valid;
		logic [7:0]          op_char;
		logic [OUT_BITS-1:0] op_length;
		logic                string_end;
		logic [OUT_BITS-1:0] query_length;
		status_t             status;
	} result_t;

endpackage
`default_nettype wire

[hdl/cigar_parser_query_length_top.sv]
// Top level of the CIGAR parser: input register, parser state, and result register.
// A character is captured in the input register; its result is then registered in the result register.
// Throughput: one character per cycle while out_stall does not hold the pipeline, set by the parse step.
// A stalled result holds the result register; one more request can wait in the input register.
// Reset clears the parser state and both valid flags, and sets req_mid_q to 1.
`default_nettype none
module cigar_parser_query_length_top
	import cpql_pkg::*;
#(
	parameter int LEN_BITS = LEN_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic                cfg_wdata,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [7:0]          char_in,
	input  wire logic                last_char,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic                     op_valid,
	output logic [7:0]               op_char,
	output logic [OUT_BITS-1:0]      op_length,
	output logic                     string_end,
	output logic [OUT_BITS-1:0]      query_length,
	output logic [2:0]               status
);

	logic                req_mid_q;
	logic                valid_s1;
	logic [7:0]          char_s1;
	logic                last_s1;
	logic [LEN_BITS-1:0] acc_q;
	logic [LEN_BITS-1:0] total_q;
	status_t             err_q;
	logic [LEN_BITS-1:0] acc_next;
	logic [LEN_BITS-1:0] total_next;
	status_t             err_next;
	result_t             res;
	result_t             res_q;
	logic                out_valid_q;
	logic                advance;
	logic                take;

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_mid_q <= 1'b1;
		end else if (cfg_we) begin
			req_mid_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			char_s1 <= char_in;
			last_s1 <= last_char;
		end
	end

	cpql_step #(
		.LEN_BITS(LEN_BITS)
	) u_step (
		.char_s1   (char_s1),
		.last_s1   (last_s1),
		.req_mid   (req_mid_q),
		.acc       (acc_q),
		.total     (total_q),
		.err       (err_q),
		.acc_next  (acc_next),
		.total_next(total_next),
		.err_next  (err_next),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			total_q     <= '0;
			err_q       <= ST_OK;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && res.has_res;
			if (valid_s1) begin
				acc_q   <= acc_next;
				total_q <= total_next;
				err_q   <= err_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign op_valid     = res_q.op_valid;
	assign op_char      = res_q.op_char;
	assign op_length    = res_q.op_length;
	assign string_end   = res_q.string_end;
	assign query_length = res_q.query_length;
	assign status       = res_q.status;

`ifndef SYNTHESIS
	a_close_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !op_valid |-> string_end && op_length == '0 && op_char == 8'h00)
		else $error("Result without an operation does not close the string.");

	a_nonzero_op: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && op_valid |-> op_length != '0)
		else $error("Operation emitted with zero length.");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && last_s1 && advance |=> err_q == ST_OK && total_q == '0 && acc_q == '0)
		else $error("Parser state not cleared after end of string.");

	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q)
		else $error("Input stalled while the pipeline can move.");
`endif

endmodule
`default_nettype wire

[hdl/cpql_step.sv]
// Per-character parse step: next parser state and the result for one character.
`default_nettype none
module cpql_step
	import cpql_pkg::*;
#(
	parameter int LEN_BITS = LEN_BITS_DEF
) (
	input  wire logic [7:0]          char_s1,
	input  wire logic                last_s1,
	input  wire logic                req_mid,
	input  wire logic [LEN_BITS-1:0] acc,
	input  wire logic [LEN_BITS-1:0] total,
	input  wire status_t             err,
	output logic      [LEN_BITS-1:0] acc_next,
	output logic      [LEN_BITS-1:0] total_next,
	output status_t                  err_next,
	output result_t                  res
);

	localparam int EXT  = LEN_BITS + 4;
	localparam int WIDE = (LEN_BITS > OUT_BITS) ? LEN_BITS : OUT_BITS;
	localparam logic [WIDE-1:0] OUT_MAX_W = WIDE'({OUT_BITS{1'b1}});

	logic                is_digit;
	logic                is_op;
	logic                counted;
	logic [3:0]          digit;
	logic [EXT-1:0]      ten_acc;
	logic                digit_ovf;
	logic [LEN_BITS:0]   sum;
	logic [LEN_BITS-1:0] acc_d;
	logic [LEN_BITS-1:0] total_d;
	status_t             err_d;
	logic                emit_op;
	logic [WIDE-1:0]     len_wide;
	logic [WIDE-1:0]     total_wide;

	assign is_digit  = (char_s1 >= CH_ZERO) && (char_s1 <= CH_NINE);
	assign is_op     = ((char_s1 >= CH_UPPER_A) && (char_s1 <= CH_UPPER_Z))
		|| (char_s1 == CH_EQUAL);
	assign counted   = (char_s1 == CH_M) || (char_s1 == CH_I);
	assign digit     = 4'(char_s1 - CH_ZERO);
	assign ten_acc   = (EXT'(acc) << 3) + (EXT'(acc) << 1) + EXT'(digit);
	assign digit_ovf = |ten_acc[EXT-1:LEN_BITS];
	assign sum       = {1'b0, total} + {1'b0, acc};

	always_comb begin
		acc_d   = acc;
		total_d = total;
		err_d   = err;
		emit_op = 1'b0;
		if (err == ST_OK) begin
			if (is_digit) begin
				if (digit_ovf) begin
					acc_d = '1;
					err_d = ST_OVERFLOW;
				end else begin
					acc_d = ten_acc[LEN_BITS-1:0];
					if (last_s1) begin
						err_d = ST_MISSING_OP;
					end
				end
			end else if (is_op) begin
				if (acc == '0) begin
					err_d = ST_ZERO_LEN;
				end else if (req_mid && !counted && (char_s1 != CH_D)) begin
					err_d = ST_UNSUPPORTED;
				end else begin
					emit_op = 1'b1;
					acc_d   = '0;
					if (counted) begin
						if (sum[LEN_BITS]) begin
							total_d = '1;
							err_d   = ST_OVERFLOW;
						end else begin
							total_d = sum[LEN_BITS-1:0];
						end
					end
				end
			end else begin
				err_d = ST_BAD_CHAR;
			end
		end
	end

	assign len_wide   = WIDE'(acc);
	assign total_wide = WIDE'(total_d);

	always_comb begin
		res.has_res      = emit_op || last_s1;
		res.op_valid     = emit_op;
		res.op_char      = emit_op ? char_s1 : 8'h00;
		res.op_length    = '0;
		if (emit_op) begin
			res.op_length = (len_wide > OUT_MAX_W) ? {OUT_BITS{1'b1}}
				: len_wide[OUT_BITS-1:0];
		end
		res.string_end   = last_s1;
		res.query_length = (total_wide > OUT_MAX_W) ? {OUT_BITS{1'b1}}
			: total_wide[OUT_BITS-1:0];
		res.status       = err_d;
	end

	// The end of a string returns the parser to its cleared state.
	assign acc_next   = last_s1 ? '0 : acc_d;
	assign total_next = last_s1 ? '0 : total_d;
	assign err_next   = last_s1 ? ST_OK : err_d;

endmodule
`default_nettype wire
